### rtl/core/bfgt_pkg.sv
// ----------------------------------------------------------------------------
// bfgt_pkg: shared constants for the bitmap font glyph table
// Request codes, register indexes, reset values and character ranges.
// ----------------------------------------------------------------------------
package bfgt_pkg;

    // Default sizes of the glyph table and the sheet column counter
    localparam int GLYPH_SLOTS_DEF = 256;
    localparam int COLUMN_BITS_DEF = 16;

    // Request codes
    localparam logic [1:0] REQ_PIXEL = 2'd0;
    localparam logic [1:0] REQ_CHAR  = 2'd1;
    localparam logic [1:0] REQ_PEN   = 2'd2;

    // Configuration register indexes
    localparam logic [0:0] CFG_KEY_COLOR      = 1'd0;
    localparam logic [0:0] CFG_LETTER_SPACING = 1'd1;

    // Register reset values
    localparam logic [31:0] KEY_COLOR_RST      = 32'h00FF_00FF;
    localparam logic [7:0]  LETTER_SPACING_RST = 8'd1;

    // Character code ranges
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_LO_FIRST = 8'd33;
    localparam logic [7:0] CHAR_HI_FIRST = 8'd126;
    localparam logic [7:0] CHAR_LO_UPPER = 8'd161;
    localparam logic [7:0] CHAR_UPPER_GAP = 8'd34;

endpackage

### rtl/core/bitmap_font_glyph_table.sv
// ----------------------------------------------------------------------------
// bitmap_font_glyph_table: glyph table builder and text layout unit
// Learns glyph columns from the top row of a font sheet and places
// characters at the pen position, advancing the pen after each one.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  ----------------------------
//  request   in         i_in_valid / o_in_stall   type, pixel, row marks,
//                                                 char code, pen position
//  result    out        o_out_valid / i_out_stall glyph pos/width, dest x/y
//  config    in         i_cfg_valid / o_cfg_ready register index, data
//
//  One item is taken per cycle while the result side does not stall; a
//  result passes the table read register, then the result register.
//  The glyph table is a one-write, one-read memory; per-entry valid bits
//  make unwritten entries read as zero, so reset needs no clearing pass.
//  A held result stalls both stages and the request side together.
//  Reset is synchronous, active low.
//
module bitmap_font_glyph_table #(
    parameter int GLYPH_SLOTS = bfgt_pkg::GLYPH_SLOTS_DEF,
    parameter int COLUMN_BITS = bfgt_pkg::COLUMN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_pixel_value,
    input  logic        i_row_first,
    input  logic        i_row_last,
    input  logic [7:0]  i_char_code,
    input  logic signed [15:0] i_pen_x,
    input  logic signed [15:0] i_pen_y,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_glyph_pos,
    output logic [15:0] o_glyph_width,
    output logic signed [15:0] o_dest_x,
    output logic signed [15:0] o_dest_y,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int IDX_W = $clog2(GLYPH_SLOTS);
    localparam int CNT_W = $clog2(GLYPH_SLOTS + 1);

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_GLYPH,
        KIND_SPACE,
        KIND_PEN
    } t_kind;

    typedef struct packed {
        logic [COLUMN_BITS-1:0] start;
        logic [COLUMN_BITS-1:0] size;
    } t_entry;

    // configuration registers
    logic [31:0] r_key_color;
    logic [7:0]  r_spacing;

    // scan state
    logic [COLUMN_BITS-1:0] r_scan_col, n_scan_col;
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_in_run, n_in_run;
    logic [COLUMN_BITS-1:0] r_run_start, n_run_start;

    // glyph table
    t_entry                 r_mem [GLYPH_SLOTS];
    logic [GLYPH_SLOTS-1:0] r_vld;

    // read stage
    logic        r_mid_valid;
    t_kind       r_mid_kind;
    logic [15:0] r_mid_pen_x, r_mid_pen_y;
    t_entry      r_rd_entry;
    logic        r_rd_hit;

    // pen and result registers
    logic [15:0] r_pen_x, r_pen_y;
    logic [15:0] n_pen_x, n_pen_y;
    logic        r_out_valid;
    logic [15:0] r_glyph_pos, r_glyph_width, r_dest_x, r_dest_y;

    logic             advance, accept;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    t_entry           wr_entry;
    logic [7:0]       char_idx;
    logic             char_draw;
    logic [IDX_W-1:0] rd_idx;
    t_kind            in_kind;
    logic [15:0]      rd_size;

    // Pipeline moves as a whole when the result register is free or taken
    assign advance    = !r_out_valid || !i_out_stall;
    assign accept     = i_in_valid && advance;
    assign o_in_stall = !advance;
    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_color <= bfgt_pkg::KEY_COLOR_RST;
            r_spacing   <= bfgt_pkg::LETTER_SPACING_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bfgt_pkg::CFG_KEY_COLOR:      r_key_color <= i_cfg_data;
                bfgt_pkg::CFG_LETTER_SPACING: r_spacing   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Row scan: find runs of non-key pixels and close them into entries
    always_comb begin
        logic [COLUMN_BITS-1:0] col;
        logic [COLUMN_BITS-1:0] start_eff;
        logic                   run_eff;
        logic [CNT_W-1:0]       cnt_eff;
        logic                   close;
        logic [COLUMN_BITS-1:0] end_col;

        col       = i_row_first ? '0 : r_scan_col;
        run_eff   = i_row_first ? 1'b0 : r_in_run;
        cnt_eff   = i_row_first ? '0 : r_count;
        start_eff = run_eff ? r_run_start : col;
        close     = 1'b0;
        end_col   = col;

        n_scan_col  = r_scan_col;
        n_count     = r_count;
        n_in_run    = r_in_run;
        n_run_start = r_run_start;

        if (accept && i_req_type == bfgt_pkg::REQ_PIXEL) begin
            n_count  = cnt_eff;
            n_in_run = run_eff;
            if (col != '0) begin
                if (i_pixel_value != r_key_color) begin
                    n_in_run    = 1'b1;
                    n_run_start = start_eff;
                    if (i_row_last) begin
                        close   = 1'b1;
                        end_col = col + 1'b1;
                    end
                end else if (run_eff) begin
                    close   = 1'b1;
                    end_col = col;
                end
            end
            if (close) begin
                n_in_run = 1'b0;
                if (cnt_eff < CNT_W'(GLYPH_SLOTS)) begin
                    n_count = cnt_eff + 1'b1;
                end
            end
            if (i_row_last) begin
                n_scan_col = '0;
                n_in_run   = 1'b0;
            end else begin
                n_scan_col = col + 1'b1;
            end
        end

        wr_en          = close && (cnt_eff < CNT_W'(GLYPH_SLOTS));
        wr_idx         = cnt_eff[IDX_W-1:0];
        wr_entry.start = start_eff;
        wr_entry.size  = end_col - start_eff;
    end

    // Hold scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_col  <= '0;
            r_count     <= '0;
            r_in_run    <= 1'b0;
            r_run_start <= '0;
        end else begin
            r_scan_col  <= n_scan_col;
            r_count     <= n_count;
            r_in_run    <= n_in_run;
            r_run_start <= n_run_start;
        end
    end

    // Map a character code to a table index and classify the request
    always_comb begin
        char_idx  = i_char_code - bfgt_pkg::CHAR_LO_FIRST;
        char_draw = 1'b0;
        if (i_char_code inside {[bfgt_pkg::CHAR_LO_FIRST:bfgt_pkg::CHAR_HI_FIRST]}) begin
            char_draw = 1'b1;
        end else if (i_char_code >= bfgt_pkg::CHAR_LO_UPPER) begin
            char_draw = 1'b1;
            char_idx  = char_idx - bfgt_pkg::CHAR_UPPER_GAP;
        end
        if (32'(char_idx) >= GLYPH_SLOTS) begin
            char_draw = 1'b0;
        end

        in_kind = KIND_NONE;
        rd_idx  = char_idx[IDX_W-1:0];
        case (i_req_type)
            bfgt_pkg::REQ_CHAR: begin
                if (i_char_code == bfgt_pkg::CHAR_SPACE) begin
                    in_kind = KIND_SPACE;
                    rd_idx  = '0;
                end else if (char_draw) begin
                    in_kind = KIND_GLYPH;
                end
            end
            bfgt_pkg::REQ_PEN: in_kind = KIND_PEN;
            default:           in_kind = KIND_NONE;
        endcase
    end

    // Glyph table: write on a closed run while the table has room, read on every transfer
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_entry;
        end
        if (accept) begin
            r_rd_entry <= r_mem[rd_idx];
        end
    end

    // Entry valid bits and the registered hit flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_idx] <= 1'b1;
            end
            if (accept) begin
                r_rd_hit <= r_vld[rd_idx];
            end
        end
    end

    // Read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
            r_mid_kind  <= KIND_NONE;
        end else if (advance) begin
            r_mid_valid <= accept;
            r_mid_kind  <= accept ? in_kind : KIND_NONE;
        end
    end

    // Read stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mid_pen_x <= i_pen_x;
            r_mid_pen_y <= i_pen_y;
        end
    end

    // Advance the pen by the glyph width plus spacing, or move it on a pen request
    assign rd_size = r_rd_hit ? 16'(r_rd_entry.size) : 16'd0;

    always_comb begin
        n_pen_x = r_pen_x;
        n_pen_y = r_pen_y;
        if (advance && r_mid_valid) begin
            case (r_mid_kind)
                KIND_GLYPH, KIND_SPACE: begin
                    n_pen_x = r_pen_x + rd_size + {8'd0, r_spacing};
                end
                KIND_PEN: begin
                    n_pen_x = r_mid_pen_x;
                    n_pen_y = r_mid_pen_y;
                end
                default: ;
            endcase
        end
    end

    // Hold pen and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x     <= '0;
            r_pen_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pen_x <= n_pen_x;
            r_pen_y <= n_pen_y;
            if (advance) begin
                r_out_valid <= r_mid_valid && (r_mid_kind == KIND_GLYPH);
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_glyph_pos   <= r_rd_hit ? 16'(r_rd_entry.start) : 16'd0;
            r_glyph_width <= rd_size;
            r_dest_x      <= r_pen_x;
            r_dest_y      <= r_pen_y;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_glyph_pos   = r_glyph_pos;
    assign o_glyph_width = r_glyph_width;
    assign o_dest_x      = r_dest_x;
    assign o_dest_y      = r_dest_y;

endmodule

### verif/glyph_layout_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_layout_checker: result predictor and scoreboard for the glyph table
// Watches the request, result and register channels of the block. Keeps its
// own copy of the glyph table, scan state, pen and registers. Queues one
// expected placement per drawable character and compares each result
// transfer field by field against the oldest one.
// ----------------------------------------------------------------------------
module glyph_layout_checker #(
    parameter int GLYPH_SLOTS = bfgt_pkg::GLYPH_SLOTS_DEF,
    parameter int COLUMN_BITS = bfgt_pkg::COLUMN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_pixel_value,
    input  logic        i_row_first,
    input  logic        i_row_last,
    input  logic [7:0]  i_char_code,
    input  logic [15:0] i_pen_x,
    input  logic [15:0] i_pen_y,
    // result channel
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_glyph_pos,
    input  logic [15:0] i_glyph_width,
    input  logic [15:0] i_dest_x,
    input  logic [15:0] i_dest_y,
    // register channel
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // status to the testbench top
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [31:0] COL_MASK = (32'd1 << COLUMN_BITS) - 32'd1;

    typedef struct packed {
        logic [15:0] pos;
        logic [15:0] width;
        logic [15:0] x;
        logic [15:0] y;
    } t_placed_glyph;

    t_placed_glyph placed_q[$];

    // Shadow of the block state
    logic [15:0] start_col [256];
    logic [15:0] glyph_len [256];
    logic [31:0] scan_col;
    int          found_glyphs;
    logic        run_open;
    logic [31:0] run_col;
    logic [15:0] pen_x;
    logic [15:0] pen_y;
    logic [31:0] key_reg;
    logic [7:0]  spacing_reg;
    int          fail_count = 0;

    // Print one line per mismatch and count it
    task automatic report_error(input string msg);
        fail_count++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // Close the open run and store it while the table has room
    task automatic close_glyph(input logic [31:0] end_col);
        logic [31:0] w;
        w = (end_col - run_col) & COL_MASK;
        if (found_glyphs < GLYPH_SLOTS && found_glyphs < 256) begin
            start_col[found_glyphs] = run_col[15:0];
            glyph_len[found_glyphs] = w[15:0];
            found_glyphs++;
        end
        run_open = 1'b0;
    endtask

    // Advance the top-row scan by one sheet pixel
    task automatic scan_pixel(input logic [31:0] pix, input logic row_start,
                              input logic row_end);
        logic [31:0] col;
        if (row_start) begin
            scan_col     = '0;
            found_glyphs = 0;
            run_open     = 1'b0;
        end
        col = scan_col & COL_MASK;
        if (col != 0) begin
            if (pix != key_reg) begin
                if (!run_open) begin
                    run_open = 1'b1;
                    run_col  = col;
                end
                if (row_end)
                    close_glyph(col + 32'd1);
            end else if (run_open) begin
                close_glyph(col);
            end
        end
        if (row_end) begin
            scan_col = '0;
            run_open = 1'b0;
        end else begin
            scan_col = (col + 32'd1) & COL_MASK;
        end
    endtask

    // Place one character at the pen and advance the pen
    task automatic place_char(input logic [7:0] code);
        int            idx;
        t_placed_glyph hit;
        if (code == bfgt_pkg::CHAR_SPACE) begin
            pen_x = pen_x + glyph_len[0] + {8'd0, spacing_reg};
        end else if (code >= bfgt_pkg::CHAR_LO_FIRST &&
                     (code <= bfgt_pkg::CHAR_HI_FIRST ||
                      code >= bfgt_pkg::CHAR_LO_UPPER)) begin
            idx = int'(code) - int'(bfgt_pkg::CHAR_LO_FIRST);
            if (code >= bfgt_pkg::CHAR_LO_UPPER)
                idx -= int'(bfgt_pkg::CHAR_UPPER_GAP);
            if (idx < GLYPH_SLOTS && idx < 256) begin
                hit.pos   = start_col[idx];
                hit.width = glyph_len[idx];
                hit.x     = pen_x;
                hit.y     = pen_y;
                placed_q.push_back(hit);
                pen_x = pen_x + glyph_len[idx] + {8'd0, spacing_reg};
            end
        end
    endtask

    always @(posedge i_clk) begin : track
        t_placed_glyph want;
        if (!i_rst_n) begin
            // Reset: clear table, scan, pen and registers
            for (int i = 0; i < 256; i++) begin
                start_col[i] = '0;
                glyph_len[i] = '0;
            end
            scan_col     = '0;
            found_glyphs = 0;
            run_open     = 1'b0;
            run_col      = '0;
            pen_x        = '0;
            pen_y        = '0;
            key_reg      = bfgt_pkg::KEY_COLOR_RST;
            spacing_reg  = bfgt_pkg::LETTER_SPACING_RST;
            placed_q.delete();
        end else begin
            // Compare a result transfer with the oldest placement
            if (i_out_valid && !i_out_stall) begin
                if (placed_q.size() == 0) begin
                    report_error($sformatf("unexpected result pos %h width %h x %h y %h",
                                           i_glyph_pos, i_glyph_width, i_dest_x, i_dest_y));
                end else begin
                    want = placed_q.pop_front();
                    if (i_glyph_pos !== want.pos)
                        report_error($sformatf("glyph_pos got %h expected %h",
                                               i_glyph_pos, want.pos));
                    if (i_glyph_width !== want.width)
                        report_error($sformatf("glyph_width got %h expected %h",
                                               i_glyph_width, want.width));
                    if (i_dest_x !== want.x)
                        report_error($sformatf("dest_x got %h expected %h",
                                               i_dest_x, want.x));
                    if (i_dest_y !== want.y)
                        report_error($sformatf("dest_y got %h expected %h",
                                               i_dest_y, want.y));
                end
            end
            // Register write
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == bfgt_pkg::CFG_KEY_COLOR)
                    key_reg = i_cfg_data;
                else if (i_cfg_index == bfgt_pkg::CFG_LETTER_SPACING)
                    spacing_reg = i_cfg_data[7:0];
            end
            // Request transfer
            if (i_in_valid && !i_in_stall) begin
                case (i_req_type)
                    bfgt_pkg::REQ_PIXEL: scan_pixel(i_pixel_value, i_row_first, i_row_last);
                    bfgt_pkg::REQ_CHAR:  place_char(i_char_code);
                    bfgt_pkg::REQ_PEN: begin
                        pen_x = i_pen_x;
                        pen_y = i_pen_y;
                    end
                    default: ;
                endcase
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= placed_q.size();
    end

endmodule

### verif/bitmap_font_glyph_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_font_glyph_table_tb: stimulus and verdict for the glyph table
// Streams font sheet rows, text and pen moves into the block with random
// idle cycles and result stalls, changes registers between phases, and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module bitmap_font_glyph_table_tb;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         ITEM_TARGET = 960;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_req_type    = bfgt_pkg::REQ_PIXEL;
    logic [31:0] i_pixel_value = '0;
    logic        i_row_first   = 1'b0;
    logic        i_row_last    = 1'b0;
    logic [7:0]  i_char_code   = '0;
    logic signed [15:0] i_pen_x = '0;
    logic signed [15:0] i_pen_y = '0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic [15:0] o_glyph_pos;
    logic [15:0] o_glyph_width;
    logic signed [15:0] o_dest_x;
    logic signed [15:0] o_dest_y;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index   = bfgt_pkg::CFG_KEY_COLOR;
    logic [31:0] i_cfg_data    = '0;

    int   fail_count;
    int   pending;
    logic calm = 1'b0;

    bitmap_font_glyph_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_pixel_value (i_pixel_value),
        .i_row_first   (i_row_first),
        .i_row_last    (i_row_last),
        .i_char_code   (i_char_code),
        .i_pen_x       (i_pen_x),
        .i_pen_y       (i_pen_y),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_glyph_pos   (o_glyph_pos),
        .o_glyph_width (o_glyph_width),
        .o_dest_x      (o_dest_x),
        .o_dest_y      (o_dest_y),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    glyph_layout_checker scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_pixel_value (i_pixel_value),
        .i_row_first   (i_row_first),
        .i_row_last    (i_row_last),
        .i_char_code   (i_char_code),
        .i_pen_x       (i_pen_x),
        .i_pen_y       (i_pen_y),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_glyph_pos   (o_glyph_pos),
        .i_glyph_width (o_glyph_width),
        .i_dest_x      (o_dest_x),
        .i_dest_y      (o_dest_y),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stall the result side at random outside calm stretches
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 36);
    end

    // Present one request and hold it until its transfer
    task automatic send_item(input logic [1:0] kind, input logic [31:0] pix,
                             input logic first, input logic last,
                             input logic [7:0] code, input logic [15:0] px,
                             input logic [15:0] py);
        while (!calm && $urandom_range(99) < 36) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= kind;
        i_pixel_value <= pix;
        i_row_first   <= first;
        i_row_last    <= last;
        i_char_code   <= code;
        i_pen_x       <= px;
        i_pen_y       <= py;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Unused fields carry random values
    task automatic send_pixel(input logic [31:0] pix, input logic first,
                              input logic last);
        send_item(bfgt_pkg::REQ_PIXEL, pix, first, last, 8'($urandom), 16'($urandom),
                  16'($urandom));
    endtask

    task automatic send_char(input logic [7:0] code);
        send_item(bfgt_pkg::REQ_CHAR, $urandom, 1'($urandom), 1'($urandom), code,
                  16'($urandom), 16'($urandom));
    endtask

    task automatic send_pen(input logic [15:0] px, input logic [15:0] py);
        send_item(bfgt_pkg::REQ_PEN, $urandom, 1'($urandom), 1'($urandom), 8'($urandom),
                  px, py);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid, wait out every outstanding result and the pipeline depth
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_pixel(input logic [31:0] key,
                                               input logic [31:0] ink);
        int roll;
        roll = $urandom_range(99);
        if (roll < 45)
            return key;
        else if (roll < 90)
            return ink;
        else
            return $urandom;
    endfunction

    function automatic logic [15:0] pick_pen();
        case ($urandom_range(3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int          sent;
        int          phase;
        int          row_len;
        int          text_len;
        int          shape;
        int          roll;
        logic [31:0] key_now;
        logic [31:0] ink;
        logic [7:0]  code;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset registers, empty table reads zero
        send_char(bfgt_pkg::CHAR_LO_FIRST);
        send_char(8'd255);
        send_pen(16'h7FFF, 16'h8000);

        // Row: ink at column 0 ignored, glyphs (2,3), (6,1), run open at row end
        send_pixel(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_pixel(bfgt_pkg::KEY_COLOR_RST, 1'b0, 1'b0);
        send_pixel(32'h0000_0000, 1'b0, 1'b0);
        send_pixel(32'h0000_0000, 1'b0, 1'b0);
        send_pixel(32'h0000_0000, 1'b0, 1'b0);
        send_pixel(bfgt_pkg::KEY_COLOR_RST, 1'b0, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_pixel(bfgt_pkg::KEY_COLOR_RST, 1'b0, 1'b0);
        send_pixel(32'h1234_5678, 1'b0, 1'b0);
        send_pixel(32'h1234_5678, 1'b0, 1'b1);

        // Text: pen wrap, space, both ranges, skipped codes, unknown request
        send_char(bfgt_pkg::CHAR_LO_FIRST);
        send_char(8'd34);
        send_char(8'd35);
        send_char(bfgt_pkg::CHAR_SPACE);
        send_char(bfgt_pkg::CHAR_HI_FIRST);
        send_char(bfgt_pkg::CHAR_LO_UPPER);
        send_char(8'd0);
        send_char(8'd31);
        send_char(8'd127);
        send_char(8'd160);
        send_item(REQ_UNUSED, $urandom, 1'b1, 1'b1, bfgt_pkg::CHAR_LO_FIRST,
                  16'($urandom), 16'($urandom));
        send_pen(16'h8000, 16'h7FFF);
        send_char(8'd34);
        drain_pipeline();

        // Table full: 270 one-pixel glyphs, extreme registers
        write_reg(bfgt_pkg::CFG_KEY_COLOR, 32'h0000_0000);
        write_reg(bfgt_pkg::CFG_LETTER_SPACING, 32'd255);
        ink = $urandom | 32'd1;
        for (int j = 0; j < 540; j++)
            send_pixel((j % 2 == 1) ? ink : 32'h0000_0000, j == 0, j == 539);
        send_char(8'd255);
        send_char(bfgt_pkg::CHAR_LO_FIRST);
        drain_pipeline();

        // Random phases: register change, one sheet row, then text
        sent  = 0;
        phase = 0;
        while (sent < ITEM_TARGET) begin
            drain_pipeline();
            calm <= (phase >= 6 && phase < 14);
            case ($urandom_range(3))
                0:       key_now = bfgt_pkg::KEY_COLOR_RST;
                1:       key_now = 32'h0000_0000;
                2:       key_now = 32'hFFFF_FFFF;
                default: key_now = $urandom;
            endcase
            write_reg(bfgt_pkg::CFG_KEY_COLOR, key_now);
            case ($urandom_range(3))
                0:       write_reg(bfgt_pkg::CFG_LETTER_SPACING, 32'd0);
                1:       write_reg(bfgt_pkg::CFG_LETTER_SPACING, 32'd255);
                2:       write_reg(bfgt_pkg::CFG_LETTER_SPACING,
                                   32'(bfgt_pkg::LETTER_SPACING_RST));
                default: write_reg(bfgt_pkg::CFG_LETTER_SPACING, $urandom_range(255));
            endcase
            ink = $urandom;
            if (ink == key_now)
                ink = ~ink;

            // Mostly well-formed rows; some lack an end, a start, or restart midway
            row_len = $urandom_range(3, 48);
            shape   = $urandom_range(9);
            for (int j = 0; j < row_len; j++) begin
                send_pixel(pick_pixel(key_now, ink),
                           (j == 0 && shape != 1) || (shape == 2 && j == row_len / 2),
                           j == row_len - 1 && shape != 0);
                sent++;
            end

            text_len = $urandom_range(4, 32);
            for (int j = 0; j < text_len; j++) begin
                roll = $urandom_range(99);
                if (roll < 8) begin
                    send_pen(pick_pen(), pick_pen());
                end else if (roll < 11) begin
                    send_item(REQ_UNUSED, $urandom, 1'($urandom), 1'($urandom),
                              8'($urandom), 16'($urandom), 16'($urandom));
                end else if (roll < 14) begin
                    send_pixel(pick_pixel(key_now, ink), 1'($urandom), 1'($urandom));
                end else if (roll < 24) begin
                    send_char(bfgt_pkg::CHAR_SPACE);
                end else if (roll < 34) begin
                    send_char(8'($urandom));
                end else begin
                    // Favor drawable codes; the low ones can hit glyphs learned from the row
                    if ($urandom_range(3) == 0)
                        code = bfgt_pkg::CHAR_LO_UPPER + 8'($urandom_range(94));
                    else
                        code = bfgt_pkg::CHAR_LO_FIRST + 8'($urandom_range(23));
                    send_char(code);
                end
                sent++;
            end
            phase++;
        end

        drain_pipeline();
        if (fail_count == 0)
            $display("bitmap_font_glyph_table test passed");
        else
            $display("bitmap_font_glyph_table test failed");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("bitmap_font_glyph_table test failed");
        $finish;
    end

endmodule
